// ----- hw/rtl/jse_pkg.sv -----
package jse_pkg;

    localparam int RUN_MAX    = 32;
    localparam int RUN_AW     = $clog2(RUN_MAX);
    localparam int RUN_LW     = $clog2(RUN_MAX + 1);
    localparam int DESC_DEPTH = 1024;
    localparam int DESC_AW    = $clog2(DESC_DEPTH);
    localparam int DESC_CW    = $clog2(DESC_DEPTH + 1);
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);

    localparam logic [1:0] KIND_CMD = 2'd0;
    localparam logic [1:0] KIND_TDO = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    localparam logic [7:0] OP_BYTES = 8'h39;
    localparam logic [7:0] OP_BITS  = 8'h3B;
    localparam logic [7:0] OP_TMS   = 8'h6B;
    localparam logic [7:0] ERR_FULL = 8'h01;
    localparam logic [7:0] ERR_NONE = 8'h02;

    typedef enum logic [2:0] {
        JOB_RUN,
        JOB_BITS,
        JOB_TMS,
        JOB_RESP
    } job_kind_t;

    // one classified request handed from front to back
    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  tms;
        logic [7:0]  tdi;
        logic [3:0]  bc;
        logic        last;
        logic        close_first;
        logic        close_after;
        logic [RUN_LW-1:0] close_len;
        logic        close_end;
    } job_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLOSE_HDR,
        ST_CLOSE_LEN_LO,
        ST_CLOSE_LEN_HI,
        ST_CLOSE_DATA,
        ST_WORK,
        ST_RESP_RD,
        ST_RESP_OUT,
        ST_RESP_FLUSH
    } state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       tdo_end;
        logic       last;
    } result_t;

endpackage

// ----- hw/rtl/jtag_shift_mpsse_encoder.sv -----
// channel  | dir | payload
// s_axis   | in  | tdata: tms_bits, tdi_bits, bit_count, resp_byte; tuser: req_type; tlast: last_pair
// m_axis   | out | tdata: out_byte; tuser: out_kind, tdo_end; tlast: out_last
// cfg      | in  | run_limit
// a command byte, tdo byte or error leaves at most one per cycle through one output register
// a run close sends a header, length low, length high and its data bytes; a bit-shift pair
// sends opcode, bit count and tdi byte; a tms pair sends three bytes per bit; a response may add a partial tdo flush
// reset is asynchronous, active low; no clearing pass
// a short request queue lets the input keep taking requests while the output stalls, until it fills,
// except that input stalls after a closing request until its run bytes are sent or refused as full
module jtag_shift_mpsse_encoder
    import jse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // tms_bits, tdi_bits, bit_count, resp_byte, pad
    input  logic        s_axis_tuser,  // req_type
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_byte
    output logic [2:0]  m_axis_tuser,  // out_kind, tdo_end
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);

    logic [5:0]        run_limit_reg;
    logic              run_we;
    logic [RUN_AW-1:0] run_waddr, run_raddr;
    logic [7:0]        run_wdata, run_rdata;
    logic              job_valid, job_ready;
    logic              close_fin;
    job_t              job;
    logic [7:0]        resp_q_reg [QDEPTH];
    logic [QAW-1:0]    rwp_reg, rrp_reg;
    result_t           res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_limit_reg <= 6'd32;
            rwp_reg <= '0;
            rrp_reg <= '0;
        end
        else
        begin
            if (cfg_valid) run_limit_reg <= cfg_data;
            if (s_axis_tvalid && s_axis_tready) rwp_reg <= rwp_reg + 1'b1;
            if (job_valid && job_ready) rrp_reg <= rrp_reg + 1'b1;
        end
    end

    // response bytes ride alongside the request queue
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready) resp_q_reg[rwp_reg] <= s_axis_tdata[20 +: 8];
    end

    jse_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .req_type(s_axis_tuser), .tms_bits(s_axis_tdata[7:0]),
        .tdi_bits(s_axis_tdata[15:8]), .bit_count(s_axis_tdata[19:16]),
        .last_pair(s_axis_tlast), .run_limit(run_limit_reg),
        .run_we(run_we), .run_waddr(run_waddr), .run_wdata(run_wdata),
        .job_valid(job_valid), .job_ready(job_ready), .close_fin(close_fin), .job(job)
    );

    jse_ram #(.WIDTH(8), .DEPTH(RUN_MAX)) u_run (
        .clk(clk), .we(run_we), .waddr(run_waddr), .wdata(run_wdata),
        .raddr(run_raddr), .rdata(run_rdata)
    );

    jse_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .resp_in(resp_q_reg[rrp_reg]), .close_fin(close_fin),
        .run_raddr(run_raddr), .run_rdata(run_rdata),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
    );

    assign m_axis_tdata = res.data;
    assign m_axis_tuser = {res.tdo_end, res.kind};
    assign m_axis_tlast = res.last;

endmodule

// ----- hw/rtl/jse_ram.sv -----
module jse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/jse_front.sv -----
module jse_front
    import jse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       req_type,
    input  logic [7:0] tms_bits,
    input  logic [7:0] tdi_bits,
    input  logic [3:0] bit_count,
    input  logic       last_pair,
    input  logic [5:0] run_limit,
    output logic             run_we,
    output logic [RUN_AW-1:0] run_waddr,
    output logic [7:0]       run_wdata,
    output logic       job_valid,
    input  logic       job_ready,
    input  logic       close_fin,
    output job_t       job
);

    logic [RUN_LW-1:0] len_reg, len_next;
    logic [QAW:0]      cnt_reg;
    logic [QAW-1:0]    wp_reg, rp_reg;
    job_t              q_reg [QDEPTH];
    job_t              nj;
    logic [3:0]        bc;
    logic [7:0]        tms;
    logic [RUN_LW-1:0] lim, len_inc;
    logic              push, pop, full_run;
    logic              close_pend_reg;

    // hold off new requests until a queued run close has read its bytes
    assign in_ready  = (cnt_reg != QDEPTH[QAW:0]) && !close_pend_reg;
    assign push      = in_valid && in_ready;
    assign job_valid = (cnt_reg != '0);
    assign job       = q_reg[rp_reg];
    assign pop       = job_valid && job_ready;

    always_comb
    begin
        bc = bit_count;
        if (bc == 4'd0) bc = 4'd1;
        if (bc > 4'd8) bc = 4'd8;
        tms = tms_bits & 8'((9'd1 << bc) - 9'd1);
        lim = (run_limit == 6'd0) ? RUN_LW'(1) :
              (run_limit > 6'(RUN_MAX)) ? RUN_LW'(RUN_MAX) : RUN_LW'(run_limit);
        full_run = (bc == 4'd8) && (tms == 8'd0);
        nj = '0;
        nj.tms = tms;
        nj.tdi = tdi_bits;
        nj.bc = bc;
        nj.last = last_pair;
        len_next = len_reg;
        len_inc = len_reg;
        run_we = 1'b0;
        run_waddr = '0;
        run_wdata = tdi_bits;
        if (req_type)
        begin
            nj.kind = JOB_RESP;
        end
        else if (full_run)
        begin
            nj.kind = JOB_RUN;
            run_we = push;
            run_waddr = len_reg[RUN_AW-1:0];
            len_inc = len_reg + 1'b1;
            nj.close_after = (len_inc >= lim) || last_pair;
            nj.close_len = len_inc;
            nj.close_end = last_pair;
            len_next = nj.close_after ? '0 : len_inc;
        end
        else
        begin
            nj.kind = (tms == 8'd0) ? JOB_BITS : JOB_TMS;
            nj.close_first = (len_reg != '0);
            nj.close_len = len_reg;
            len_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= nj;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            cnt_reg <= '0;
            wp_reg  <= '0;
            rp_reg  <= '0;
            close_pend_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
                if (!req_type) len_reg <= len_next;
            end
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop);
            if (push && (nj.close_first || nj.close_after))
                close_pend_reg <= 1'b1;
            else if (close_fin)
                close_pend_reg <= 1'b0;
        end
    end

endmodule

// ----- hw/rtl/jse_back.sv -----
module jse_back
    import jse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    output logic       job_ready,
    input  job_t       job,
    input  logic [7:0] resp_in,
    output logic       close_fin,
    output logic [RUN_AW-1:0] run_raddr,
    input  logic [7:0] run_rdata,
    output logic       res_valid,
    input  logic       res_ready,
    output result_t    res
);

    state_t            state_reg, state_next;
    job_t              job_reg;
    logic [7:0]        resp_reg;
    logic [RUN_LW-1:0] idx_reg, idx_next;
    logic [3:0]        bit_reg, bit_next;
    logic [DESC_AW-1:0] wp_reg, rp_reg;
    logic [DESC_CW-1:0] dc_reg;
    logic [7:0]        acc_reg;
    logic [2:0]        fill_reg;
    logic [7:0]        flush_reg;
    logic              ov_valid_reg;
    result_t           ov_reg;
    logic              emit;
    result_t           e;
    logic              d_we;
    logic [4:0]        d_wdata, d_rdata;
    logic              take, do_pop, fire;
    logic [DESC_CW-1:0] free_slots;
    logic [7:0]        ob_reg [3];
    logic [1:0]        ocnt_reg;
    logic              err_reg;
    logic [3:0]        n;
    logic [4:0]        total;
    logic [15:0]       accw;
    logic              dend;
    logic [7:0]        shifted;
    logic [RUN_LW-1:0] nm1;
    logic              run_done, close_done, run_closing, pending_main;

    assign free_slots = DESC_CW'(DESC_DEPTH) - dc_reg;
    assign res_valid  = ov_valid_reg;
    assign res        = ov_reg;
    assign fire       = !ov_valid_reg || res_ready;
    assign close_fin  = close_done;

    jse_ram #(.WIDTH(5), .DEPTH(DESC_DEPTH)) u_desc (
        .clk(clk), .we(d_we), .waddr(wp_reg), .wdata(d_wdata),
        .raddr(rp_reg), .rdata(d_rdata)
    );

    assign run_raddr = idx_next[RUN_AW-1:0];
    assign job_ready = (state_reg == ST_IDLE);
    assign take      = job_valid && job_ready;
    assign nm1       = job_reg.close_len - 1'b1;

    always_comb
    begin
        n = {1'b0, d_rdata[2:0]} + 4'd1;
        dend = d_rdata[3];
        shifted = resp_reg >> (4'd8 - n);
        accw = {8'd0, acc_reg} | ({8'd0, shifted} << fill_reg);
        total = {2'b0, fill_reg} + {1'b0, n};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        bit_next = bit_reg;
        run_closing = job_reg.close_first ||
                      (job_reg.kind == JOB_RUN && job_reg.close_after);
        run_done = (idx_reg + 1'b1 == job_reg.close_len);
        pending_main = (job_reg.kind == JOB_BITS) || (job_reg.kind == JOB_TMS);
        close_done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    idx_next = '0;
                    bit_next = '0;
                    if (job.kind == JOB_RESP)
                        state_next = ST_RESP_RD;
                    else if (job.close_first ||
                             (job.kind == JOB_RUN && job.close_after))
                        state_next = ST_CLOSE_HDR;
                    else if (job.kind == JOB_RUN)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_WORK;
                end
            end
            ST_CLOSE_HDR:
            begin
                if (fire)
                begin
                    if (free_slots < DESC_CW'(job_reg.close_len))
                        close_done = 1'b1;
                    else
                        state_next = ST_CLOSE_LEN_LO;
                end
            end
            ST_CLOSE_LEN_LO: if (fire) state_next = ST_CLOSE_LEN_HI;
            ST_CLOSE_LEN_HI: if (fire) state_next = ST_CLOSE_DATA;
            ST_CLOSE_DATA:
            begin
                if (fire)
                begin
                    if (run_done) close_done = 1'b1;
                    else idx_next = idx_reg + 1'b1;
                end
            end
            ST_WORK:
            begin
                if (fire)
                begin
                    if (job_reg.kind == JOB_BITS)
                    begin
                        if (free_slots == '0 || bit_reg == 4'd2)
                            state_next = ST_IDLE;
                        else
                            bit_next = bit_reg + 1'b1;
                    end
                    else
                    begin
                        if (free_slots == '0 || ocnt_reg == 2'd2)
                        begin
                            if (bit_reg + 1'b1 == job_reg.bc)
                                state_next = ST_IDLE;
                            else
                                bit_next = bit_reg + 1'b1;
                        end
                    end
                end
            end
            ST_RESP_RD: state_next = ST_RESP_OUT;
            ST_RESP_OUT:
            begin
                if (fire)
                begin
                    if (err_reg) state_next = ST_IDLE;
                    else if (total >= 5'd8 && dend && total > 5'd8)
                        state_next = ST_RESP_FLUSH;
                    else state_next = ST_IDLE;
                end
            end
            ST_RESP_FLUSH: if (fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        if (close_done)
        begin
            idx_next = '0;
            state_next = pending_main ? ST_WORK : ST_IDLE;
        end
    end

    // outputs
    always_comb
    begin
        emit = 1'b0;
        e = '0;
        e.kind = KIND_CMD;
        d_we = 1'b0;
        d_wdata = '0;
        do_pop = 1'b0;
        case (state_reg)
            ST_CLOSE_HDR:
            begin
                emit = 1'b1;
                if (free_slots < DESC_CW'(job_reg.close_len))
                begin
                    e.kind = KIND_ERR;
                    e.data = ERR_FULL;
                    e.last = !pending_main;
                end
                else e.data = OP_BYTES;
            end
            ST_CLOSE_LEN_LO:
            begin
                emit = 1'b1;
                e.data = 8'(nm1);
            end
            ST_CLOSE_LEN_HI:
            begin
                emit = 1'b1;
                e.data = 8'({8'd0, nm1} >> 8);
            end
            ST_CLOSE_DATA:
            begin
                emit = 1'b1;
                e.data = run_rdata;
                e.last = run_done && !pending_main;
                d_we = fire;
                d_wdata = {1'b0, run_done && job_reg.close_end, 3'd7};
            end
            ST_WORK:
            begin
                emit = 1'b1;
                if (free_slots == '0)
                begin
                    e.kind = KIND_ERR;
                    e.data = ERR_FULL;
                    e.last = (job_reg.kind == JOB_BITS) ||
                             (bit_reg + 1'b1 == job_reg.bc);
                end
                else if (job_reg.kind == JOB_BITS)
                begin
                    e.data = (bit_reg == 4'd0) ? OP_BITS :
                             (bit_reg == 4'd1) ? 8'(job_reg.bc - 4'd1) : job_reg.tdi;
                    e.last = (bit_reg == 4'd2);
                    d_we = fire && (bit_reg == 4'd2);
                    d_wdata = {1'b0, job_reg.last, 3'(job_reg.bc - 4'd1)};
                end
                else
                begin
                    e.data = ob_reg[ocnt_reg];
                    e.last = (ocnt_reg == 2'd2) && (bit_reg + 1'b1 == job_reg.bc);
                    d_we = fire && (ocnt_reg == 2'd2);
                    d_wdata = {1'b0, job_reg.last && (bit_reg + 1'b1 == job_reg.bc),
                               3'd0};
                end
            end
            ST_RESP_OUT:
            begin
                do_pop = fire && !err_reg;
                if (err_reg)
                begin
                    emit = 1'b1;
                    e.kind = KIND_ERR;
                    e.data = ERR_NONE;
                    e.last = 1'b1;
                end
                else if (total >= 5'd8)
                begin
                    emit = 1'b1;
                    e.kind = KIND_TDO;
                    e.data = accw[7:0];
                    e.tdo_end = dend && (total == 5'd8);
                    e.last = !(dend && total > 5'd8);
                end
                else if (dend && total != 5'd0)
                begin
                    emit = 1'b1;
                    e.kind = KIND_TDO;
                    e.data = accw[7:0];
                    e.tdo_end = 1'b1;
                    e.last = 1'b1;
                end
            end
            ST_RESP_FLUSH:
            begin
                emit = 1'b1;
                e.kind = KIND_TDO;
                e.data = flush_reg;
                e.tdo_end = 1'b1;
                e.last = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ob_reg[0] = OP_TMS;
        ob_reg[1] = 8'h00;
        ob_reg[2] = {job_reg.tdi[bit_reg[2:0]], 6'd0, job_reg.tms[bit_reg[2:0]]};
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg  <= job;
            resp_reg <= resp_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            bit_reg      <= '0;
            ocnt_reg     <= '0;
            wp_reg       <= '0;
            rp_reg       <= '0;
            dc_reg       <= '0;
            acc_reg      <= '0;
            fill_reg     <= '0;
            flush_reg    <= '0;
            err_reg      <= 1'b0;
            ov_valid_reg <= 1'b0;
            ov_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            bit_reg   <= bit_next;
            if (take)
            begin
                ocnt_reg <= '0;
                err_reg  <= (dc_reg == '0);
            end
            else if (state_reg == ST_WORK && job_reg.kind == JOB_TMS && fire)
            begin
                if (free_slots == '0 || ocnt_reg == 2'd2) ocnt_reg <= '0;
                else ocnt_reg <= ocnt_reg + 1'b1;
            end
            if (fire)
            begin
                ov_valid_reg <= emit;
                ov_reg       <= e;
            end
            if (d_we) wp_reg <= wp_reg + 1'b1;
            if (do_pop)
            begin
                rp_reg <= rp_reg + 1'b1;
                if (dend)
                begin
                    acc_reg  <= '0;
                    fill_reg <= '0;
                    flush_reg <= accw[15:8];
                end
                else if (total >= 5'd8)
                begin
                    acc_reg  <= accw[15:8];
                    fill_reg <= 3'(total - 5'd8);
                end
                else
                begin
                    acc_reg  <= accw[7:0];
                    fill_reg <= 3'(total);
                end
            end
            dc_reg <= dc_reg + DESC_CW'(d_we) - DESC_CW'(do_pop);
        end
    end

endmodule

// ----- hw/rtl/jse_checker.sv -----
module jse_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[1:0] != 2'd3) else $error("bad kind");

    a_end_tdo: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == 2'd1)
        else $error("tdo_end on non tdo");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == 2'd2 && m_axis_tdata == 8'd2
        |-> m_axis_tlast) else $error("no descriptor error not last");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stall dropped");

endmodule

bind jtag_shift_mpsse_encoder jse_checker u_chk (.*);

// ----- bench/mpsse_stream_checker.sv -----
`timescale 1ns / 1ps

module mpsse_stream_checker
    import jse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    output int          mismatches,
    output int          pending,
    output int          desc_level
);

    result_t    expected_results[$];
    logic [4:0] tdo_descs[$];
    logic [7:0] run_data[RUN_MAX];
    int         run_len;
    int         run_limit;
    int         tdo_acc;
    int         tdo_fill;

    assign pending    = expected_results.size();
    assign desc_level = tdo_descs.size();

    function automatic void emit(logic [1:0] kind, logic [7:0] data, logic tdo_end);
        result_t r;
        r.kind    = kind;
        r.data    = data;
        r.tdo_end = tdo_end;
        r.last    = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic int free_descs();
        return DESC_DEPTH - tdo_descs.size();
    endfunction

    function automatic void close_run(logic vec_end);
        int n;
        n = run_len;
        if (n == 0)
            return;
        run_len = 0;
        if (free_descs() < n)
        begin
            emit(KIND_ERR, ERR_FULL, 1'b0);
            return;
        end
        emit(KIND_CMD, OP_BYTES, 1'b0);
        emit(KIND_CMD, 8'(n - 1), 1'b0);
        emit(KIND_CMD, 8'((n - 1) >> 8), 1'b0);
        for (int i = 0; i < n; i++)
        begin
            emit(KIND_CMD, run_data[i], 1'b0);
            tdo_descs.push_back({1'b0, (vec_end && i == n - 1), 3'd7});
        end
    endfunction

    function automatic void encode_pair(logic [7:0] tms_in, logic [7:0] tdi,
                                        logic [3:0] bc_in, logic last);
        int         bc;
        int         lim;
        logic [7:0] tms;
        bc  = (bc_in == 0) ? 1 : (bc_in > 8) ? 8 : bc_in;
        tms = tms_in & 8'((9'd1 << bc) - 1);
        if (bc == 8 && tms == 0)
        begin
            if (run_len >= RUN_MAX)
                close_run(1'b0);
            run_data[run_len] = tdi;
            run_len++;
            lim = (run_limit == 0) ? 1 : (run_limit > RUN_MAX) ? RUN_MAX : run_limit;
            if (run_len >= lim || last)
                close_run(last);
            return;
        end
        close_run(1'b0);
        if (tms == 0)
        begin
            if (free_descs() == 0)
            begin
                emit(KIND_ERR, ERR_FULL, 1'b0);
                return;
            end
            emit(KIND_CMD, OP_BITS, 1'b0);
            emit(KIND_CMD, 8'(bc - 1), 1'b0);
            emit(KIND_CMD, tdi, 1'b0);
            tdo_descs.push_back({1'b0, last, 3'(bc - 1)});
            return;
        end
        for (int i = 0; i < bc; i++)
        begin
            if (free_descs() == 0)
            begin
                emit(KIND_ERR, ERR_FULL, 1'b0);
                continue;
            end
            emit(KIND_CMD, OP_TMS, 1'b0);
            emit(KIND_CMD, 8'h00, 1'b0);
            emit(KIND_CMD, {tdi[i], 6'd0, tms[i]}, 1'b0);
            tdo_descs.push_back({1'b0, (last && i == bc - 1), 3'd0});
        end
    endfunction

    function automatic void unpack_response(logic [7:0] resp);
        logic [4:0] d;
        int         n;
        int         total;
        int         acc;
        if (tdo_descs.size() == 0)
        begin
            emit(KIND_ERR, ERR_NONE, 1'b0);
            return;
        end
        d     = tdo_descs.pop_front();
        n     = d[2:0] + 1;
        acc   = tdo_acc | ((int'(resp) >> (8 - n)) << tdo_fill);
        total = tdo_fill + n;
        if (total >= 8)
        begin
            emit(KIND_TDO, 8'(acc), d[3] && total == 8);
            acc   = acc >> 8;
            total = total - 8;
        end
        if (d[3])
        begin
            if (total > 0)
                emit(KIND_TDO, 8'(acc), 1'b1);
            acc   = 0;
            total = 0;
        end
        tdo_acc  = acc & 8'hFF;
        tdo_fill = total;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int      before_len;
        result_t want;
        if (!rst_n)
        begin
            expected_results.delete();
            tdo_descs.delete();
            run_len    = 0;
            run_limit  = 32;
            tdo_acc    = 0;
            tdo_fill   = 0;
            mismatches = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                run_limit = int'(cfg_data);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result kind %0d byte %h end %b last %b",
                                 m_axis_tuser[1:0], m_axis_tdata, m_axis_tuser[2],
                                 m_axis_tlast);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.kind != m_axis_tuser[1:0] || want.data != m_axis_tdata ||
                        want.tdo_end != m_axis_tuser[2] || want.last != m_axis_tlast)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %0d/%h/%b/%b got %0d/%h/%b/%b",
                                     want.kind, want.data, want.tdo_end, want.last,
                                     m_axis_tuser[1:0], m_axis_tdata, m_axis_tuser[2],
                                     m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                before_len = expected_results.size();
                if (!s_axis_tuser)
                    encode_pair(s_axis_tdata[7:0], s_axis_tdata[15:8],
                                s_axis_tdata[19:16], s_axis_tlast);
                else
                    unpack_response(s_axis_tdata[27:20]);
                if (expected_results.size() > before_len)
                    expected_results[expected_results.size() - 1].last = 1'b1;
            end
        end
    end

endmodule

// ----- bench/jtag_shift_mpsse_encoder_test.sv -----
`timescale 1ns / 1ps

module jtag_shift_mpsse_encoder_test;
    import jse_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int REQ_VECTOR  = 0;
    localparam int REQ_RESP    = 1;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [5:0]  cfg_data;
    int          mismatches;
    int          pending;
    int          desc_level;
    int          cycles;
    int          burst_left;
    int          stall_mode;
    int          requests_sent;

    jtag_shift_mpsse_encoder dut (.*);

    mpsse_stream_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver stall pattern switches at random among always ready, half random and sparse styles
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles % 64 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_request(int kind, logic [7:0] tms, logic [7:0] tdi,
                                logic [3:0] bc, logic last, logic [7:0] resp);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 10);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind[0];
        s_axis_tlast  <= last;
        if (kind == REQ_RESP)
            s_axis_tdata <= {4'd0, resp, 20'($urandom)};
        else
            s_axis_tdata <= {4'd0, 8'($urandom), bc, tdi, tms};
        forever
        begin
            @(negedge clk);
            if (s_axis_tready)
                break;
        end
        @(posedge clk);
        requests_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_run_limit(logic [5:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        forever
        begin
            @(negedge clk);
            if (cfg_ready)
                break;
        end
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_responses(int extra);
        int n;
        n = desc_level + extra;
        for (int i = 0; i < n; i++)
            send_request(REQ_RESP, 8'd0, 8'd0, 4'd0, 1'b0, 8'($urandom));
    endtask

    task automatic random_vector();
        int         len;
        logic [7:0] tms;
        logic [3:0] bc;
        len = $urandom_range(0, 4) == 0 ? $urandom_range(20, 45) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
        begin
            tms = $urandom_range(0, 4) == 0 ? 8'($urandom) : 8'h00;
            bc  = 4'd8;
            if (i == len - 1 && $urandom_range(0, 2) == 0)
                bc = 4'($urandom_range(0, 15));
            send_request(REQ_VECTOR, tms, 8'($urandom), bc, i == len - 1, 8'($urandom));
        end
    endtask

    initial
    begin
        logic [5:0] limits[6];
        rst_n         = 1'b0;
        cycles        = 0;
        stall_mode    = 0;
        burst_left    = 0;
        requests_sent = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        limits        = '{6'd1, 6'd0, 6'd63, 6'd5, 6'd32, 6'd17};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // response with nothing queued, then the basic command shapes
        send_request(REQ_RESP, 0, 0, 0, 0, 8'hFF);
        send_request(REQ_VECTOR, 8'h00, 8'h00, 4'd8, 0, 0);
        send_request(REQ_VECTOR, 8'h00, 8'hFF, 4'd8, 0, 0);
        send_request(REQ_VECTOR, 8'h00, 8'hA5, 4'd8, 1, 0);
        send_request(REQ_VECTOR, 8'hF0, 8'h5A, 4'd4, 1, 0);
        send_request(REQ_VECTOR, 8'hFF, 8'hAA, 4'd8, 0, 0);
        send_request(REQ_VECTOR, 8'h01, 8'hFF, 4'd0, 0, 0);
        send_request(REQ_VECTOR, 8'h00, 8'h81, 4'd15, 0, 0);
        send_request(REQ_VECTOR, 8'h00, 8'h3C, 4'd3, 1, 0);
        send_request(REQ_VECTOR, 8'h55, 8'h0F, 4'd8, 1, 0);
        send_request(REQ_RESP, 0, 0, 0, 0, 8'h00);
        send_request(REQ_RESP, 0, 0, 0, 0, 8'hFF);
        drain_responses(2);
        wait_idle();

        foreach (limits[k])
        begin
            write_run_limit(limits[k]);
            while (requests_sent < 30 * (k + 1) + 35)
            begin
                random_vector();
                if ($urandom_range(0, 3) == 0)
                    wait_idle();
                drain_responses($urandom_range(0, 6) == 0 ? 1 : 0);
            end
            wait_idle();
        end

        // fill the descriptor queue past its depth
        for (int i = 0; i < 130; i++)
            send_request(REQ_VECTOR, 8'hFF, 8'($urandom), 4'd8, i == 129, 0);
        for (int i = 0; i < 3; i++)
            send_request(REQ_VECTOR, 8'h00, 8'($urandom), 4'd8, 1, 0);
        for (int i = 0; i < 2; i++)
            send_request(REQ_RESP, 8'd0, 8'd0, 4'd0, 1'b0, 8'($urandom));
        wait_idle();

        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- jtag_shift_mpsse_encoder.f -----
hw/rtl/jse_pkg.sv
hw/rtl/jse_ram.sv
hw/rtl/jse_front.sv
hw/rtl/jse_back.sv
hw/rtl/jtag_shift_mpsse_encoder.sv
hw/rtl/jse_checker.sv
bench/mpsse_stream_checker.sv
bench/jtag_shift_mpsse_encoder_test.sv
